// ===== hw/rtl/lsaf_pkg.sv =====
// shared constants and register indexes for the led strip animation frame block
package lsaf_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgAddrW-1:0] REG_ANIM_TYPE    = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_BASE_COLOR   = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_TRAIL_LENGTH = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_SPEED        = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_DIRECTION_UP = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_BRIGHTNESS   = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_LED_COUNT    = 3'd6;

  localparam logic [1:0] ANIM_BREATHE = 2'd0;
  localparam logic [1:0] ANIM_RUNNING = 2'd1;
  localparam logic [1:0] ANIM_BOUNCE  = 2'd2;
  // unused mode code, every pixel dark
  localparam logic [1:0] ANIM_OFF     = 2'd3;

  localparam logic [10:0] MIN_CYCLE_MS = 11'd200;
  localparam logic [10:0] MAX_CYCLE_MS = 11'd2000;
  localparam logic [6:0]  PERCENT      = 7'd100;

  // floor(x/100) == (x*5243) >> 19 for every x below 43690
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

endpackage

// ===== hw/rtl/led_strip_animation_frame.sv =====
// led strip animation frame generator around one shared iterative divider
//
//  channel  | direction | handshake             | payload
//  s_axis   | in        | tvalid / tready       | tdata[31:0] elapsed_ms
//  m_axis   | out       | tvalid / tready       | tdata index, red, green, blue; tlast last
//  cfg      | in        | cfg_valid / cfg_ready | cfg_addr register index, cfg_data value
//
// one elapsed_ms transaction yields n-1 pixels, n = led_count capped at MaxLeds, if n >= 2
// the 32-step restoring divider sets the pace: it runs once in frame setup
// (once more for breathing), then once for each pixel inside the trail in
// trail modes; pixels outside the trail skip the divider
// s_axis_tready is high only when no frame is being worked on
// a stalled m_axis holds the sequencer before it loads the next pixel
// asynchronous active-low reset returns config registers to their defaults
module led_strip_animation_frame #(
  parameter int unsigned MaxLeds = 65
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] elapsed_ms
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [6:0] led_index, [14:7] red, [22:15] green,
                                        // [30:23] blue, [31] zero
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [lsaf_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [lsaf_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MOD  = 4'd1;
  localparam logic [3:0] ST_SET1 = 4'd2;
  localparam logic [3:0] ST_SET2 = 4'd3;
  localparam logic [3:0] ST_BDIV = 4'd4;
  localparam logic [3:0] ST_PIX  = 4'd5;
  localparam logic [3:0] ST_PDIV = 4'd6;
  localparam logic [3:0] ST_COL1 = 4'd7;
  localparam logic [3:0] ST_COL2 = 4'd8;
  localparam logic [3:0] ST_COL3 = 4'd9;
  localparam logic [3:0] ST_COL4 = 4'd10;

  localparam logic [6:0] MaxLedsC = 7'(MaxLeds);

  // configuration registers
  logic [1:0]  anim_q;
  logic [23:0] color_q;
  logic [3:0]  trail_q;
  logic [6:0]  speed_q;
  logic        dir_q;
  logic [6:0]  bright_q;
  logic [6:0]  count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anim_q   <= 2'd0;
      color_q  <= 24'h400000;
      trail_q  <= 4'd1;
      speed_q  <= 7'd25;
      dir_q    <= 1'b1;
      bright_q <= 7'd35;
      count_q  <= 7'd17;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        lsaf_pkg::REG_ANIM_TYPE:    anim_q   <= cfg_data_i[1:0];
        lsaf_pkg::REG_BASE_COLOR:   color_q  <= cfg_data_i;
        lsaf_pkg::REG_TRAIL_LENGTH: trail_q  <= cfg_data_i[3:0];
        lsaf_pkg::REG_SPEED:        speed_q  <= cfg_data_i[6:0];
        lsaf_pkg::REG_DIRECTION_UP: dir_q    <= cfg_data_i[0];
        lsaf_pkg::REG_BRIGHTNESS:   bright_q <= cfg_data_i[6:0];
        lsaf_pkg::REG_LED_COUNT:    count_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // saturated views of the registers
  logic [6:0]  n_w, spd_w, bri_w;
  logic [3:0]  t_w;
  logic [5:0]  l_w;
  logic [10:0] c_w;
  assign n_w   = (count_q > MaxLedsC) ? MaxLedsC : count_q;
  assign spd_w = (speed_q > lsaf_pkg::PERCENT) ? lsaf_pkg::PERCENT : speed_q;
  assign bri_w = (bright_q > lsaf_pkg::PERCENT) ? lsaf_pkg::PERCENT : bright_q;
  assign t_w   = (trail_q == 4'd0) ? 4'd1 : trail_q;
  assign l_w   = 6'((n_w - 7'd1) >> 1);
  // 1800*(100-spd)/100 is exactly 18*(100-spd)
  assign c_w   = (spd_w == 7'd0) ? lsaf_pkg::MAX_CYCLE_MS
               : lsaf_pkg::MIN_CYCLE_MS + 11'd18 * {4'd0, lsaf_pkg::PERCENT - spd_w};

  logic [3:0]  state_q;
  logic [10:0] cyc_q, p_q;
  logic [5:0]  l_q;
  logic [16:0] lc_q, pl_q, b_q, half_q, ctr_q, posc_q;
  logic [14:0] tc_q;
  logic [11:0] num2_q;
  logic [6:0]  v_q, idx_q, pct_q;
  logic [14:0] prod_q [3];

  // shared restoring divider: quotient shifts into div_num_q
  logic [31:0] div_num_q;
  logic [14:0] div_rem_q, div_den_q;
  logic [5:0]  div_cnt_q;
  logic        div_load;
  logic [31:0] div_num_d;
  logic [14:0] div_den_d;
  logic [15:0] div_trial;
  logic        div_ge;

  assign div_trial = {div_rem_q, div_num_q[31]};
  assign div_ge    = div_trial >= {1'b0, div_den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= 6'd0;
    end else if (div_load) begin
      div_cnt_q <= 6'd32;
    end else if (div_cnt_q != 6'd0) begin
      div_cnt_q <= div_cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_load) begin
      div_num_q <= div_num_d;
      div_den_q <= div_den_d;
      div_rem_q <= '0;
    end else if (div_cnt_q != 6'd0) begin
      div_rem_q <= div_ge ? 15'(div_trial - {1'b0, div_den_q}) : div_trial[14:0];
      div_num_q <= {div_num_q[30:0], div_ge};
    end
  end

  // scaled distance of the current pixel from the trail center
  logic [17:0] diff_w;
  logic [16:0] ad_w, d_w;
  logic        in_trail_w, trail_mode_w;
  assign diff_w = {1'b0, posc_q} - {1'b0, (anim_q == lsaf_pkg::ANIM_RUNNING) ? b_q : ctr_q};
  assign ad_w   = diff_w[17] ? 17'(-diff_w) : diff_w[16:0];
  // running light wraps around the column
  assign d_w    = ((anim_q == lsaf_pkg::ANIM_RUNNING) && (ad_w > half_q)) ? lc_q - ad_w : ad_w;
  assign trail_mode_w = (anim_q == lsaf_pkg::ANIM_RUNNING) || (anim_q == lsaf_pkg::ANIM_BOUNCE);
  assign in_trail_w   = ({1'b0, idx_q} <= {l_q, 1'b0}) && (d_w <= {2'd0, tc_q});

  logic [10:0] half_p_w;
  assign half_p_w = ({p_q, 1'b0} <= {1'b0, cyc_q}) ? p_q : cyc_q - p_q;

  logic        out_free;
  logic        out_valid_q, out_last_q;
  logic [6:0]  out_idx_q;
  logic [7:0]  out_ch_q [3];
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    div_load  = 1'b0;
    div_num_d = s_axis_tdata_i;
    div_den_d = {4'd0, c_w};
    unique case (state_q)
      ST_IDLE: div_load = s_axis_tvalid_i && (n_w >= 7'd2);
      ST_SET2: begin
        div_load  = (anim_q == lsaf_pkg::ANIM_BREATHE);
        div_num_d = {21'd0, half_p_w} * 32'd200;
        div_den_d = {4'd0, cyc_q};
      end
      ST_PIX: begin
        div_load  = (anim_q != lsaf_pkg::ANIM_BREATHE) && trail_mode_w && in_trail_w;
        div_num_d = {17'd0, 15'(tc_q - d_w[14:0])} * 32'd100;
        div_den_d = tc_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_COL4) && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid_i && n_w >= 7'd2) state_q <= ST_MOD;
        ST_MOD:  if (div_cnt_q == 6'd0) state_q <= ST_SET1;
        ST_SET1: state_q <= ST_SET2;
        ST_SET2: state_q <= (anim_q == lsaf_pkg::ANIM_BREATHE) ? ST_BDIV : ST_PIX;
        ST_BDIV: if (div_cnt_q == 6'd0) state_q <= ST_PIX;
        ST_PIX:  state_q <= div_load ? ST_PDIV : ST_COL1;
        ST_PDIV: if (div_cnt_q == 6'd0) state_q <= ST_COL1;
        ST_COL1: state_q <= ST_COL2;
        ST_COL2: state_q <= ST_COL3;
        ST_COL3: state_q <= ST_COL4;
        ST_COL4: begin
          if (out_free) begin
            state_q <= (idx_q == n_w - 7'd1) ? ST_IDLE : ST_PIX;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: cyc_q <= c_w;
      ST_MOD:  p_q <= div_rem_q[10:0];
      ST_SET1: begin
        l_q    <= l_w;
        lc_q   <= {11'd0, l_w} * {6'd0, cyc_q};
        pl_q   <= {11'd0, l_w} * {6'd0, p_q};
        tc_q   <= {11'd0, t_w} * {4'd0, cyc_q};
        num2_q <= ({p_q, 1'b0} < {1'b0, cyc_q}) ? {p_q, 1'b0}
                : 12'({cyc_q, 1'b0} - {p_q, 1'b0});
      end
      ST_SET2: begin
        b_q    <= dir_q ? pl_q : lc_q - pl_q;
        half_q <= {12'd0, l_q[5:1]} * {6'd0, cyc_q};
        ctr_q  <= {5'd0, num2_q} * {11'd0, l_q - 6'd1};
        idx_q  <= 7'd1;
        posc_q <= '0;
      end
      ST_BDIV: v_q <= div_num_q[6:0];
      ST_PIX: begin
        // column position times cycle: rises in column 0, holds, falls in column 1
        if ({1'b0, idx_q} < {1'b0, l_q}) posc_q <= posc_q + {6'd0, cyc_q};
        else if ({1'b0, idx_q} > {1'b0, l_q}) posc_q <= posc_q - {6'd0, cyc_q};
        if (anim_q == lsaf_pkg::ANIM_BREATHE) pct_q <= v_q;
        else pct_q <= 7'd0;
      end
      ST_PDIV: pct_q <= div_num_q[6:0];
      ST_COL1: begin
        prod_q[0] <= {7'd0, color_q[23:16]} * {8'd0, pct_q};
        prod_q[1] <= {7'd0, color_q[15:8]} * {8'd0, pct_q};
        prod_q[2] <= {7'd0, color_q[7:0]} * {8'd0, pct_q};
      end
      ST_COL2: begin
        for (int j = 0; j < 3; j++)
          prod_q[j] <= 15'((28'(prod_q[j]) * lsaf_pkg::RECIP_100) >> lsaf_pkg::RECIP_SHIFT);
      end
      ST_COL3: begin
        for (int j = 0; j < 3; j++) prod_q[j] <= {7'd0, prod_q[j][7:0]} * {8'd0, bri_w};
      end
      ST_COL4: begin
        if (out_free) begin
          for (int j = 0; j < 3; j++)
            out_ch_q[j] <= 8'((28'(prod_q[j]) * lsaf_pkg::RECIP_100) >> lsaf_pkg::RECIP_SHIFT);
          out_idx_q  <= idx_q;
          out_last_q <= (idx_q == n_w - 7'd1);
          idx_q      <= idx_q + 7'd1;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_ch_q[2], out_ch_q[1], out_ch_q[0], out_idx_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  // status pixel zero is never produced
  a_no_pixel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_idx_q != 7'd0) else $error("pixel zero emitted");
  // last flag only on the final pixel of the frame
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> out_idx_q == n_w - 7'd1) else $error("bad last");
  // divider runs only in the states that wait on it
  a_div_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_cnt_q != 6'd0) |-> (state_q == ST_MOD || state_q == ST_BDIV || state_q == ST_PDIV))
    else $error("divider busy outside a divide state");
  // a stalled output is not overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> $stable(out_idx_q)) else $error("output lost");
`endif

endmodule

// ===== test/tb_led_strip_animation_frame.sv =====
// self-checking testbench for the led strip animation frame generator
`timescale 1ns / 1ps

module tb_led_strip_animation_frame;

  typedef struct packed {
    logic [6:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [lsaf_pkg::CfgAddrW-1:0] cfg_addr_i;
  logic [lsaf_pkg::CfgDataW-1:0] cfg_data_i;

  // shadow copy of the register file
  logic [1:0]  sh_anim;
  logic [23:0] sh_color;
  logic [3:0]  sh_trail;
  logic [6:0]  sh_speed;
  logic        sh_dir_up;
  logic [6:0]  sh_bright;
  logic [6:0]  sh_leds;

  pixel_t pending_pixels[$];
  int     err_count;
  int     src_idle_pct;
  int     snk_stall_pct;
  int     hold_len;

  led_strip_animation_frame u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // intensity percent of a trail pixel at scaled distance d over span tc
  function automatic longint trail_percent(longint d, longint tc);
    if (d > tc) return 0;
    return ((tc - d) * 100) / tc;
  endfunction

  // works out the whole frame for one elapsed time and queues its pixels
  function automatic void predict_frame(logic [31:0] elapsed);
    longint n, spd, bri, t, c, p, l, tc, b, half, num, centre, pos, d, v;
    longint pct[65];
    pixel_t px;
    int idx;
    n   = (sh_leds > 65) ? 65 : sh_leds;
    spd = (sh_speed > 100) ? 100 : sh_speed;
    bri = (sh_bright > 100) ? 100 : sh_bright;
    t   = (sh_trail == 0) ? 1 : sh_trail;
    if (n < 2) return;
    c  = (spd == 0) ? 2000 : 200 + (1800 * (100 - spd)) / 100;
    p  = longint'(elapsed) % c;
    l  = (n - 1) / 2;
    tc = t * c;
    foreach (pct[i]) pct[i] = 0;
    case (sh_anim)
      lsaf_pkg::ANIM_BREATHE: begin
        v = (2 * p <= c) ? (200 * p) / c : (200 * (c - p)) / c;
        for (int i = 1; i < n; i++) pct[i] = v;
      end
      lsaf_pkg::ANIM_RUNNING: begin
        b    = sh_dir_up ? p * l : l * c - p * l;
        half = (l / 2) * c;
        for (int col = 0; col < 2; col++) begin
          for (int k = 0; k < l; k++) begin
            pos = (col == 0) ? k : l - 1 - k;
            d   = pos * c - b;
            if (d < 0) d = -d;
            if (d > half) d = l * c - d;
            idx = int'(1 + col * l + k);
            if (idx < 65) pct[idx] = trail_percent(d, tc);
          end
        end
      end
      lsaf_pkg::ANIM_BOUNCE: begin
        num    = (2 * p < c) ? 2 * p : 2 * c - 2 * p;
        centre = num * (l - 1);
        for (int col = 0; col < 2; col++) begin
          for (int k = 0; k < l; k++) begin
            pos = (col == 0) ? k : l - 1 - k;
            d   = pos * c - centre;
            if (d < 0) d = -d;
            idx = int'(1 + col * l + k);
            if (idx < 65) pct[idx] = trail_percent(d, tc);
          end
        end
      end
      default: ;  // unused mode leaves every pixel dark
    endcase
    for (int i = 1; i < n; i++) begin
      px.led_index = i[6:0];
      px.red   = 8'((((longint'(sh_color[23:16]) * pct[i]) / 100) * bri) / 100);
      px.green = 8'((((longint'(sh_color[15:8]) * pct[i]) / 100) * bri) / 100);
      px.blue  = 8'((((longint'(sh_color[7:0]) * pct[i]) / 100) * bri) / 100);
      px.last  = (i == n - 1);
      pending_pixels.push_back(px);
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR %0t: %s", $realtime, what);
    err_count++;
  endtask

  // pixel checker: every m_axis transaction against the oldest expectation
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.led_index = m_axis_tdata_o[6:0];
      got.red       = m_axis_tdata_o[14:7];
      got.green     = m_axis_tdata_o[22:15];
      got.blue      = m_axis_tdata_o[30:23];
      got.last      = m_axis_tlast_o;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %0d", got.led_index));
      end else begin
        want = pending_pixels.pop_front();
        if (got.led_index != want.led_index)
          report_mismatch($sformatf("index %0d want %0d", got.led_index, want.led_index));
        if (got.red != want.red)
          report_mismatch($sformatf("pixel %0d red %0d want %0d",
                                    want.led_index, got.red, want.red));
        if (got.green != want.green)
          report_mismatch($sformatf("pixel %0d green %0d want %0d",
                                    want.led_index, got.green, want.green));
        if (got.blue != want.blue)
          report_mismatch($sformatf("pixel %0d blue %0d want %0d",
                                    want.led_index, got.blue, want.blue));
        if (got.last != want.last)
          report_mismatch($sformatf("pixel %0d last %0b want %0b",
                                    want.led_index, got.last, want.last));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when one is requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_len > 0) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // hold-off counter
  always begin
    wait (hold_len > 0);
    repeat (hold_len) @(posedge clk_i);
    hold_len = 0;
  end

  task automatic write_reg(logic [lsaf_pkg::CfgAddrW-1:0] addr,
                           logic [lsaf_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (addr)
      lsaf_pkg::REG_ANIM_TYPE:    sh_anim   = data[1:0];
      lsaf_pkg::REG_BASE_COLOR:   sh_color  = data[23:0];
      lsaf_pkg::REG_TRAIL_LENGTH: sh_trail  = data[3:0];
      lsaf_pkg::REG_SPEED:        sh_speed  = data[6:0];
      lsaf_pkg::REG_DIRECTION_UP: sh_dir_up = data[0];
      lsaf_pkg::REG_BRIGHTNESS:   sh_bright = data[6:0];
      lsaf_pkg::REG_LED_COUNT:    sh_leds   = data[6:0];
      default: ;
    endcase
  endtask

  // one elapsed_ms transaction, with an optional random gap before it
  task automatic send_frame(logic [31:0] elapsed);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= elapsed;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_frame(elapsed);
  endtask

  // wait for every pixel, then idle before returning
  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_all(logic [1:0] anim, logic [23:0] color, logic [3:0] trail,
                           logic [6:0] spd, logic dir, logic [6:0] bri, logic [6:0] leds);
    write_reg(lsaf_pkg::REG_ANIM_TYPE, lsaf_pkg::CfgDataW'(anim));
    write_reg(lsaf_pkg::REG_BASE_COLOR, color);
    write_reg(lsaf_pkg::REG_TRAIL_LENGTH, lsaf_pkg::CfgDataW'(trail));
    write_reg(lsaf_pkg::REG_SPEED, lsaf_pkg::CfgDataW'(spd));
    write_reg(lsaf_pkg::REG_DIRECTION_UP, lsaf_pkg::CfgDataW'(dir));
    write_reg(lsaf_pkg::REG_BRIGHTNESS, lsaf_pkg::CfgDataW'(bri));
    write_reg(lsaf_pkg::REG_LED_COUNT, lsaf_pkg::CfgDataW'(leds));
  endtask

  task automatic test_reset_defaults;
    send_frame(32'd0);
    send_frame(32'd700);
    drain();
  endtask

  task automatic test_breathing;
    // slowest cycle, phase peak, saturated brightness and led count
    write_all(lsaf_pkg::ANIM_BREATHE, 24'hFFFFFF, 4'd1, 7'd0, 1'b1, 7'd127, 7'd127);
    send_frame(32'd1000);
    send_frame(32'hFFFFFFFF);
    drain();
    write_all(lsaf_pkg::ANIM_BREATHE, 24'h80FF01, 4'd1, 7'd127, 1'b1, 7'd0, 7'd3);
    send_frame(32'd100);
    drain();
    write_reg(lsaf_pkg::REG_BRIGHTNESS, 24'd100);
    send_frame(32'd100);
    send_frame(32'd199);
    drain();
  endtask

  task automatic test_trail_modes;
    write_all(lsaf_pkg::ANIM_RUNNING, 24'hFF8040, 4'd0, 7'd100, 1'b1, 7'd100, 7'd65);
    send_frame(32'd0);
    send_frame(32'd150);
    drain();
    write_all(lsaf_pkg::ANIM_RUNNING, 24'h12FF7F, 4'd15, 7'd50, 1'b0, 7'd100, 7'd10);
    send_frame(32'd333);
    send_frame(32'hAAAAAAAA);
    drain();
    write_all(lsaf_pkg::ANIM_BOUNCE, 24'hFFFFFF, 4'd8, 7'd1, 1'b1, 7'd100, 7'd64);
    send_frame(32'd0);
    send_frame(32'd991);
    send_frame(32'h55555555);
    drain();
    // leftover odd pixel, two-led strip and led counts with no pixels
    write_all(lsaf_pkg::ANIM_BOUNCE, 24'hFFFFFF, 4'd2, 7'd100, 1'b1, 7'd100, 7'd2);
    send_frame(32'd50);
    drain();
    write_reg(lsaf_pkg::REG_LED_COUNT, 24'd1);
    send_frame(32'd50);
    drain();
    write_reg(lsaf_pkg::REG_LED_COUNT, 24'd0);
    send_frame(32'd50);
    drain();
    write_all(lsaf_pkg::ANIM_OFF, 24'hFFFFFF, 4'd1, 7'd100, 1'b1, 7'd100, 7'd8);
    send_frame(32'd10);
    drain();
  endtask

  task automatic random_config;
    logic [6:0] leds;
    leds = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(24, 3));
    write_all(2'($urandom_range(3)), 24'($urandom), 4'($urandom_range(15)),
              7'($urandom_range(127)), 1'($urandom_range(1)), 7'($urandom_range(127)), leds);
  endtask

  task automatic test_random_phase(int idle, int stall, int count);
    src_idle_pct  = idle;
    snk_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if (i % 9 == 0) begin
        drain();
        random_config();
      end
      send_frame(($urandom_range(1)) ? $urandom : 32'($urandom_range(4000)));
    end
    drain();
  endtask

  task automatic test_backpressure;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    write_all(lsaf_pkg::ANIM_RUNNING, 24'h3366FF, 4'd3, 7'd70, 1'b1, 7'd90, 7'd12);
    hold_len = 3000;
    for (int i = 0; i < 4; i++) send_frame($urandom);
    drain();
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_addr_i      = '0;
    cfg_data_i      = '0;
    err_count       = 0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    hold_len        = 0;
    sh_anim   = lsaf_pkg::ANIM_BREATHE;
    sh_color  = 24'h400000;
    sh_trail  = 4'd1;
    sh_speed  = 7'd25;
    sh_dir_up = 1'b1;
    sh_bright = 7'd35;
    sh_leds   = 7'd17;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_breathing();
    test_trail_modes();
    test_random_phase(0, 0, 30);
    test_random_phase(80, 0, 30);
    test_random_phase(0, 80, 30);
    test_random_phase(20, 20, 28);
    test_backpressure();

    if (err_count == 0) begin
      $display("led_strip_animation_frame test passed");
    end else begin
      $display("led_strip_animation_frame test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("led_strip_animation_frame test failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lsaf_pkg.sv
hw/rtl/led_strip_animation_frame.sv
test/tb_led_strip_animation_frame.sv
